// ===== sv/sdbe_pkg.sv =====
// shared types and codes for the sample delta byte encoder
// no dependencies

package sdbe_pkg;

  localparam logic [1:0] OP_LONE  = 2'd0;
  localparam logic [1:0] OP_FIRST = 2'd1;
  localparam logic [1:0] OP_NEXT  = 2'd2;

  localparam logic [7:0] ESC_RAW = 8'h80;
  localparam logic [7:0] ESC_NEG = 8'h81;
  localparam logic [7:0] ESC_POS = 8'h82;

  localparam logic [16:0] NEG_OFFSET = 17'd126;
  localparam logic [16:0] POS_OFFSET = 17'd128;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // one coded item: up to three bytes and the index of its last byte
  typedef struct packed {
    logic [1:0] last_idx;
    logic [7:0] byte2;
    logic [7:0] byte1;
    logic [7:0] byte0;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

endpackage

// ===== sv/sdbe_front.sv =====
// front part: accepts items, forms the delta of a following sample and codes each item into a command
// depends on sdbe_pkg

module sdbe_front import sdbe_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      op_i,
  input  logic [7:0]      raw_byte_i,
  input  logic signed [15:0] sample_i,
  input  logic            queue_full_i,
  output cmd_req_t        push_o
);

  logic [15:0] prev_q, prev_d;
  logic        accept;
  logic signed [16:0] delta;
  logic signed [16:0] neg_delta;
  logic [16:0] neg_byte;
  logic [16:0] pos_byte;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;

  assign delta     = {sample_i[15], sample_i} - {prev_q[15], prev_q};
  assign neg_delta = -delta;
  assign neg_byte  = neg_delta - NEG_OFFSET;
  assign pos_byte  = delta - POS_OFFSET;

  always_comb begin
    push_o       = '0;
    prev_d       = prev_q;
    unique case (op_i)
      OP_LONE: begin
        push_o.valid        = accept;
        push_o.cmd.byte0    = raw_byte_i;
        push_o.cmd.last_idx = 2'd0;
      end
      OP_FIRST: begin
        push_o.valid        = accept;
        push_o.cmd.byte0    = sample_i[7:0];
        push_o.cmd.byte1    = sample_i[15:8];
        push_o.cmd.last_idx = 2'd1;
        if (accept) prev_d = sample_i;
      end
      OP_NEXT: begin
        push_o.valid = accept;
        if (accept) prev_d = sample_i;
        if (delta >= -17'sd125 && delta <= 17'sd127) begin
          push_o.cmd.byte0    = delta[7:0];
          push_o.cmd.last_idx = 2'd0;
        end else if (delta >= -17'sd381 && delta <= -17'sd126) begin
          push_o.cmd.byte0    = ESC_NEG;
          push_o.cmd.byte1    = neg_byte[7:0];
          push_o.cmd.last_idx = 2'd1;
        end else if (delta >= 17'sd128 && delta <= 17'sd383) begin
          push_o.cmd.byte0    = ESC_POS;
          push_o.cmd.byte1    = pos_byte[7:0];
          push_o.cmd.last_idx = 2'd1;
        end else begin
          push_o.cmd.byte0    = ESC_RAW;
          push_o.cmd.byte1    = sample_i[7:0];
          push_o.cmd.byte2    = sample_i[15:8];
          push_o.cmd.last_idx = 2'd2;
        end
      end
      default: begin
        push_o.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else begin
      prev_q <= prev_d;
    end
  end

endmodule

// ===== sv/sdbe_queue.sv =====
// short command queue between the front and back parts
// depends on sdbe_pkg

module sdbe_queue import sdbe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cmd_req_t push_i,
  input  logic     pop_i,
  output logic     full_o,
  output cmd_req_t head_o
);

  cmd_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o       = (count_q == QueueCntW'(QueueDepth));
  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];

  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    if (do_pop)  rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    if (do_push && !do_pop)      count_d = count_q + 1'b1;
    else if (!do_push && do_pop) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_i.cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== sv/sdbe_back.sv =====
// back part: walks the bytes of the head command into the output register
// depends on sdbe_pkg

module sdbe_back import sdbe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_req_t   head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_end_o
);

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       run_end_q, run_end_d;
  logic       load;
  logic       is_last;
  logic [7:0] sel_byte;

  assign load    = head_i.valid && (!out_valid_q || !out_stall_i);
  assign is_last = (idx_q == head_i.cmd.last_idx);
  assign pop_o   = load && is_last;

  always_comb begin
    unique case (idx_q)
      2'd0:    sel_byte = head_i.cmd.byte0;
      2'd1:    sel_byte = head_i.cmd.byte1;
      default: sel_byte = head_i.cmd.byte2;
    endcase
  end

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    run_end_d   = run_end_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_byte_d  = sel_byte;
      run_end_d   = is_last;
      idx_d       = is_last ? 2'd0 : idx_q + 2'd1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    run_end_q  <= run_end_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_end_o   = run_end_q;

endmodule

// ===== sv/sample_delta_byte_encoder.sv =====
// top level of the sample delta byte encoder: front, command queue and back
// depends on sdbe_pkg, sdbe_front, sdbe_queue and sdbe_back
//
//   channel  handshake              payload
//   in       in_valid_i/in_stall_o  op_i, raw_byte_i, sample_i
//   out      out_valid_o/out_stall_i out_byte_o, run_end_o
//
// the output emits one byte a cycle unless out_stall_i holds it; an item
// codes to one to three bytes: one for a lone byte or short delta, two for a
// first sample or short escape, three for a raw escape
// a two-entry command queue lets the front take items while bytes drain
// reset clears the previous sample to zero and empties the queue
// an item of op 3 is taken and dropped

module sample_delta_byte_encoder import sdbe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic [7:0]         raw_byte_i,
  input  logic signed [15:0] sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic               run_end_o
);

  cmd_req_t push;
  cmd_req_t head;
  logic     queue_full;
  logic     pop;

  sdbe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .raw_byte_i  (raw_byte_i),
    .sample_i    (sample_i),
    .queue_full_i(queue_full),
    .push_o      (push)
  );

  sdbe_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .pop_i (pop),
    .full_o(queue_full),
    .head_o(head)
  );

  sdbe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .run_end_o  (run_end_o)
  );

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for the sample delta byte encoder
// predicts the coded byte stream per item and checks it against the output channel
// depends on sdbe_pkg and sample_delta_byte_encoder

module tb;
  import sdbe_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int StallLimit = 2000;
  localparam int HoldCycles = 80;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } coded_byte_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [1:0]         op_i        = OP_LONE;
  logic [7:0]         raw_byte_i  = 8'h00;
  logic signed [15:0] sample_i    = 16'sd0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [7:0]         out_byte_o;
  logic               run_end_o;

  coded_byte_t        pending_bytes [$];
  logic signed [15:0] last_sample = 16'sd0;
  bit                 failed = 1'b0;
  int                 quiet_cycles = 0;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  int                 hold_req = 0;
  int                 hold_ack = 0;
  int                 hold_left = 0;

  sample_delta_byte_encoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .raw_byte_i  (raw_byte_i),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .run_end_o   (run_end_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void push_byte(input logic [7:0] value, input logic last);
    coded_byte_t b;
    b.value = value;
    b.last  = last;
    pending_bytes.push_back(b);
  endfunction

  function automatic void encode_item(input logic [1:0] op, input logic [7:0] raw,
                                      input logic signed [15:0] s);
    int delta;
    delta = int'(s) - int'(last_sample);
    case (op)
      OP_LONE: begin
        push_byte(raw, 1'b1);
      end
      OP_FIRST: begin
        push_byte(s[7:0], 1'b0);
        push_byte(s[15:8], 1'b1);
        last_sample = s;
      end
      OP_NEXT: begin
        last_sample = s;
        if (delta >= -125 && delta <= 127) begin
          push_byte(8'(delta), 1'b1);
        end else if (delta >= -381 && delta <= -126) begin
          push_byte(ESC_NEG, 1'b0);
          push_byte(8'(-delta - int'(NEG_OFFSET)), 1'b1);
        end else if (delta >= 128 && delta <= 383) begin
          push_byte(ESC_POS, 1'b0);
          push_byte(8'(delta - int'(POS_OFFSET)), 1'b1);
        end else begin
          push_byte(ESC_RAW, 1'b0);
          push_byte(s[7:0], 1'b0);
          push_byte(s[15:8], 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  // both channels are sampled at the falling edge, where everything has settled
  always @(negedge clk_i) begin : monitor
    coded_byte_t want;
    bit moved;
    moved = 1'b0;
    if (rst_ni && in_valid_i === 1'b1 && in_stall_o === 1'b0) begin
      encode_item(op_i, raw_byte_i, sample_i);
      moved = 1'b1;
    end
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      moved = 1'b1;
      if (pending_bytes.size() == 0) begin
        $error("unexpected output byte %h run_end %b", out_byte_o, run_end_o);
        failed = 1'b1;
      end else begin
        want = pending_bytes.pop_front();
        if (out_byte_o !== want.value) begin
          $error("out_byte: expected %h, got %h", want.value, out_byte_o);
          failed = 1'b1;
        end
        if (run_end_o !== want.last) begin
          $error("run_end: expected %b, got %b", want.last, run_end_o);
          failed = 1'b1;
        end
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when asked for
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      hold_left   <= HoldCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [7:0] raw,
                           input logic signed [15:0] s);
    bit stalled;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    raw_byte_i <= raw;
    sample_i   <= s;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (pending_bytes.size() != 0);
  endtask

  // following sample straight after reset codes against zero
  task automatic test_next_after_reset();
    send_item(OP_NEXT, 8'h3C, 16'sd5);
  endtask

  task automatic test_lone_bytes();
    send_item(OP_LONE, 8'h00, 16'sh7FFF);
    send_item(OP_LONE, 8'hFF, -16'sd32768);
    send_item(OP_LONE, 8'hA5, 16'sh0000);
    send_item(OP_LONE, 8'h5A, -16'sd1);
  endtask

  task automatic test_first_samples();
    send_item(OP_FIRST, 8'hFF, -16'sd32768);
    send_item(OP_FIRST, 8'h00, 16'sd32767);
  endtask

  // each band boundary of the delta code, then the widest jumps
  task automatic test_delta_edges();
    send_item(OP_FIRST, 8'h00, 16'sd0);
    send_item(OP_NEXT, 8'h00, 16'sd127);
    send_item(OP_NEXT, 8'h00, 16'sd2);
    send_item(OP_NEXT, 8'h00, -16'sd124);
    send_item(OP_NEXT, 8'h00, -16'sd505);
    send_item(OP_NEXT, 8'h00, -16'sd887);
    send_item(OP_NEXT, 8'h00, -16'sd759);
    send_item(OP_NEXT, 8'h00, -16'sd376);
    send_item(OP_NEXT, 8'h00, 16'sd8);
    send_item(OP_NEXT, 8'h00, -16'sd32768);
    send_item(OP_NEXT, 8'h00, 16'sd32767);
    send_item(OP_NEXT, 8'h00, 16'sd32767);
  endtask

  // unused selector must leave the previous sample alone
  task automatic test_unused_op();
    send_item(OP_UNUSED, 8'hFF, -16'sd32768);
    send_item(OP_UNUSED, 8'h00, 16'sd0);
    send_item(OP_NEXT, 8'h81, 16'sd32766);
  endtask

  task automatic run_random(input int count);
    int sent;
    int d;
    logic signed [15:0] s;
    sent = 0;
    s = 16'sd0;
    while (sent < count) begin
      case ($urandom_range(19))
        0, 1: begin
          send_item(OP_LONE, 8'($urandom), 16'($urandom));
          sent++;
        end
        2: send_item(OP_UNUSED, 8'($urandom), 16'($urandom));
        3: wait_drained();
        4: begin
          s = 16'($urandom);
          send_item(OP_NEXT, 8'($urandom), s);
          sent++;
        end
        default: begin
          s = 16'($urandom);
          send_item(OP_FIRST, 8'($urandom), s);
          sent++;
          repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(5))
              0, 1: d = $urandom_range(0, 252) - 125;
              2: d = -$urandom_range(126, 381);
              3: d = $urandom_range(128, 383);
              4: d = int'($urandom_range(0, 65535)) - 32768;
              default: begin
                case ($urandom_range(3))
                  0: d = -125 - $urandom_range(1);
                  1: d = 127 + $urandom_range(1);
                  2: d = -381 - $urandom_range(1);
                  default: d = 383 + $urandom_range(1);
                endcase
              end
            endcase
            s = 16'(int'(s) + d);
            send_item(OP_NEXT, 8'($urandom), s);
            sent++;
          end
        end
      endcase
    end
  endtask

  // sender stops until every byte has come out, then carries on
  task automatic test_sender_pause();
    send_item(OP_FIRST, 8'h00, 16'sd1000);
    send_item(OP_NEXT, 8'h00, -16'sd20000);
    send_item(OP_NEXT, 8'h00, -16'sd20200);
    wait_drained();
    send_item(OP_NEXT, 8'h00, -16'sd20000);
  endtask

  // long receiver hold-off while the sender keeps offering raw escapes
  task automatic test_receiver_holdoff();
    int i;
    hold_req <= hold_req + 1;
    send_item(OP_FIRST, 8'h00, 16'sd0);
    for (i = 0; i < 12; i++) begin
      send_item(OP_NEXT, 8'($urandom), (i % 2 == 0) ? 16'sh4000 : -16'sh4000);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 33;
    recv_idle_pct <= 83;
    test_next_after_reset();
    test_lone_bytes();
    test_first_samples();
    test_delta_edges();
    test_unused_op();
    run_random(70);
    test_sender_pause();

    send_idle_pct = 83;
    recv_idle_pct <= 33;
    run_random(70);

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    test_receiver_holdoff();
    run_random(65);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (failed) begin
      $display("Simulation FAILED");
    end else begin
      $display("Simulation PASSED");
    end
    $finish;
  end

endmodule
